### hw/rtl/vad_pkg.sv
// ----------------------------------------------------------------------------
// vad_pkg
// Shared constants, state encodings and divider status for the
// velocity / acceleration backward difference block.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_VEL,
    ST_DV,
    ST_ACC,
    ST_WRITE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN,
    DIV_FIN
  } div_state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_status_t;

endpackage

### hw/rtl/velocity_acceleration_difference.sv
// ----------------------------------------------------------------------------
// velocity_acceleration_difference: backward difference velocity/acceleration
// a first sample or zero time step skips the divider; else two serial
// divisions run on one bit-serial divider; one item at a time, next item
// taken after the result is moved to the output register. Sync reset clears
// history and out_valid.
// ----------------------------------------------------------------------------
module velocity_acceleration_difference import vad_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] sample_time,
  input  logic signed [WORD_BITS-1:0] position,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] velocity,
  output logic signed [WORD_BITS-1:0] acceleration,
  output logic                        zero_step,
  output logic                        saturated
);

  ctrl_state_t state, state_next;

  logic [WORD_BITS-1:0] last_time;
  logic [WORD_BITS-1:0] last_position;
  logic [WORD_BITS-1:0] last_velocity;
  logic                 have_previous;

  logic [WORD_BITS-1:0] cur_time;
  logic [WORD_BITS-1:0] cur_pos;
  logic                 first;
  logic [WORD_BITS:0]   dt_r;
  logic [WORD_BITS:0]   dx_r;
  logic [WORD_BITS:0]   dv_r;
  logic [WORD_BITS-1:0] vel_r;
  logic [WORD_BITS-1:0] acc_r;
  logic                 sat_r;
  logic                 zero_r;

  logic                 accept;
  logic                 out_free;
  logic                 dt_zero;
  logic                 div_start;
  logic [WORD_BITS:0]   div_num;
  div_status_t          div_status;
  logic [WORD_BITS-1:0] div_quot;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;
  assign dt_zero   = (dt_r == '0);
  assign div_start = ((state == ST_DIFF) & ~first & ~dt_zero) | (state == ST_DV);
  assign div_num   = (state == ST_DV) ? dv_r : dx_r;

  vad_div #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (dt_r),
    .status (div_status),
    .quot   (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = (first | dt_zero) ? ST_WRITE : ST_VEL;
      end
      ST_VEL: begin
        if (div_status.done) state_next = ST_DV;
      end
      ST_DV: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (div_status.done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      have_previous <= 1'b0;
    end else begin
      if (state == ST_WRITE && out_free) begin
        out_valid     <= 1'b1;
        have_previous <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // history registers clear on reset, working registers do not
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      last_position <= '0;
      last_velocity <= '0;
    end else if (state == ST_WRITE && out_free) begin
      last_time     <= cur_time;
      last_position <= cur_pos;
      last_velocity <= vel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_time <= sample_time;
      cur_pos  <= position;
      first    <= restart | ~have_previous;
      dt_r     <= {sample_time[WORD_BITS-1], sample_time}
                  - {last_time[WORD_BITS-1], last_time};
      dx_r     <= {position[WORD_BITS-1], position}
                  - {last_position[WORD_BITS-1], last_position};
    end
    if (state == ST_DIFF) begin
      vel_r  <= '0;
      acc_r  <= '0;
      sat_r  <= 1'b0;
      zero_r <= ~first & dt_zero;
    end
    if (state == ST_VEL && div_status.done) begin
      vel_r <= div_quot;
      sat_r <= sat_r | div_status.sat;
      // acceleration works from the saturated velocity
      dv_r  <= {div_quot[WORD_BITS-1], div_quot}
               - {last_velocity[WORD_BITS-1], last_velocity};
    end
    if (state == ST_ACC && div_status.done) begin
      acc_r <= div_quot;
      sat_r <= sat_r | div_status.sat;
    end
    if (state == ST_WRITE && out_free) begin
      velocity     <= vel_r;
      acceleration <= acc_r;
      zero_step    <= zero_r;
      saturated    <= sat_r;
    end
  end

endmodule

### hw/rtl/vad_div.sv
// ----------------------------------------------------------------------------
// vad_div
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated to the signed WORD_BITS range. One quotient bit
// per cycle, numerator bits shifted in MSB first.
// ----------------------------------------------------------------------------
module vad_div import vad_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS:0]   num,
  input  logic [WORD_BITS:0]   den,
  output div_status_t          status,
  output logic [WORD_BITS-1:0] quot
);

  localparam int NW    = WORD_BITS + FRAC_BITS + 1;
  localparam int CW    = (FRAC_BITS > WORD_BITS) ? FRAC_BITS + 1 : WORD_BITS + 1;
  localparam int CNT_W = $clog2(WORD_BITS);

  div_state_t state, state_next;

  logic [WORD_BITS:0]   num_mag;
  logic [WORD_BITS:0]   den_mag;
  logic                 neg;
  logic                 big;
  logic [WORD_BITS:0]   rem;
  logic [WORD_BITS-1:0] nshift;
  logic [WORD_BITS-1:0] qacc;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic                 sat;

  logic [NW-1:0]        n_full;
  logic [FRAC_BITS:0]   n_hi;
  logic [WORD_BITS-1:0] n_lo;
  logic                 big_now;
  logic [WORD_BITS+1:0] rs;
  logic [WORD_BITS+1:0] diff;
  logic                 fits;
  logic [WORD_BITS-1:0] lim;
  logic                 over;
  logic [WORD_BITS-1:0] qsel;

  always_comb begin
    n_full  = NW'(num_mag) << FRAC_BITS;
    n_hi    = n_full[NW-1:WORD_BITS];
    n_lo    = n_full[WORD_BITS-1:0];
    // quotient reaches 2^WORD_BITS or more: no need to iterate
    big_now = CW'(n_hi) >= CW'(den_mag);
    rs      = {rem, nshift[WORD_BITS-1]};
    diff    = rs - {1'b0, den_mag};
    fits    = rs >= {1'b0, den_mag};
    // largest magnitude allowed, one more on the negative side
    lim     = {1'b0, {(WORD_BITS-1){1'b1}}} + WORD_BITS'(neg);
    over    = big | (qacc > lim);
    qsel    = over ? lim : qacc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) state_next = DIV_CHECK;
      end
      DIV_CHECK: begin
        state_next = big_now ? DIV_FIN : DIV_RUN;
      end
      DIV_RUN: begin
        if (cnt == CNT_W'(WORD_BITS - 1)) state_next = DIV_FIN;
      end
      DIV_FIN: begin
        state_next = DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DIV_IDLE: begin
          if (start) begin
            num_mag <= num[WORD_BITS] ? (WORD_BITS+1)'(0) - num : num;
            den_mag <= den[WORD_BITS] ? (WORD_BITS+1)'(0) - den : den;
            neg     <= num[WORD_BITS] ^ den[WORD_BITS];
          end
        end
        DIV_CHECK: begin
          big    <= big_now;
          rem    <= (WORD_BITS+1)'(n_hi);
          nshift <= n_lo;
          qacc   <= '0;
          cnt    <= '0;
        end
        DIV_RUN: begin
          rem    <= fits ? diff[WORD_BITS:0] : rs[WORD_BITS:0];
          nshift <= nshift << 1;
          qacc   <= {qacc[WORD_BITS-2:0], fits};
          cnt    <= cnt + CNT_W'(1);
        end
        DIV_FIN: begin
          quot <= neg ? WORD_BITS'(0) - qsel : qsel;
          sat  <= over;
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.done = done;
    status.sat  = sat;
  end

endmodule

### hw/rtl/vad_checker.sv
// ----------------------------------------------------------------------------
// vad_checker
// Port-level checks for the backward difference block, bound to the top.
// ----------------------------------------------------------------------------
module vad_checker import vad_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [WORD_BITS-1:0] velocity,
  input logic signed [WORD_BITS-1:0] acceleration,
  input logic                        zero_step,
  input logic                        saturated
);

  // a held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(velocity) &&
      $stable(acceleration) && $stable(zero_step) && $stable(saturated))
    else $error("output item changed while stalled");

  // zero time step forces zero results without saturation
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_step |-> velocity == '0 && acceleration == '0 && !saturated)
    else $error("zero step item with nonzero fields");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind velocity_acceleration_difference vad_checker #(
  .WORD_BITS (WORD_BITS)
) u_vad_checker (.*);
